// ----- design/ppe_pkg.sv -----
// ppe_pkg: shared types and constants of the perimeter energy delta unit.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package ppe_pkg;

    // configuration register indexes
    localparam logic CFG_GAIN   = 1'b0;
    localparam logic CFG_TARGET = 1'b1;

    localparam logic [15:0] GAIN_RESET   = 16'd128;  // 0.5 in units of 1/256
    localparam logic [15:0] TARGET_RESET = 16'd256;  // 16.0 in units of 1/16

    localparam int ENERGY_BITS = 48;
    localparam int CFG_BITS    = 16;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_SAME  = 2'd2
    } status_t;

    // perimeter change 4 - 2n for n matching neighbours
    function automatic logic signed [3:0] perim_change(input logic [2:0] n);
        logic signed [3:0] c;
        unique case (n)
            3'd0:    c = 4'sd4;
            3'd1:    c = 4'sd2;
            3'd2:    c = 4'sd0;
            3'd3:    c = -4'sd2;
            3'd4:    c = -4'sd4;
            default: c = 4'sd0;
        endcase
        return c;
    endfunction

endpackage

// ----- design/potts_perimeter_energy_delta_unit.sv -----
// Perimeter-constraint energy change for a 2D cellular Potts lattice update.
// Depends on ppe_pkg (status codes, register indexes, perimeter change table).
`timescale 1ns / 1ps

// Usage
//   s_* : one transaction per proposed site copy. tdata carries the cell ids
//         and perimeters, tuser the occupied flags and neighbour valid mask.
//   m_* : one transaction per proposal, tdata = energy change (signed, units
//         of 2^-16, saturated to 48 bits), tuser = status code.
//   cfg_*: register writes (lambda, target perimeter); always ready. Write
//         only while no proposal is in flight.
// Timing
//   Five register stages: match/count and deviation, deviation change,
//   multiply by lambda, sum of both cells, saturation into the output
//   register. Throughput is one proposal per cycle while the output is not
//   stalled; the single lambda multiplier per cell is the deepest stage and
//   sets the clock.
// Reset
//   rst_n clears all stage valid bits and loads lambda = 0.5, P0 = 16.0.
// Stall
//   While m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated. s_tready follows m_tready
//   combinationally when the output register is full.
module potts_perimeter_energy_delta_unit #(
    parameter int CELL_ID_BITS   = 16,
    parameter int PERIMETER_BITS = 12
) (
    input  logic clk,
    input  logic rst_n,

    // slave side
    input  logic s_tvalid,
    output logic s_tready,
    // tdata, lowest bit up: source_cell, target_cell, neighbour_a, neighbour_b,
    // neighbour_c, neighbour_d, source_perimeter, target_perimeter_now, zero fill
    input  logic [((6*CELL_ID_BITS + 2*PERIMETER_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser, lowest bit up: source_occupied, target_occupied, neighbour_valid[3:0]
    input  logic [5:0] s_tuser,

    // master side
    output logic m_tvalid,
    input  logic m_tready,
    // tdata: energy_delta (signed)
    output logic [ppe_pkg::ENERGY_BITS-1:0] m_tdata,
    // tuser: status
    output logic [1:0] m_tuser,

    // configuration
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_index,
    input  logic [ppe_pkg::CFG_BITS-1:0] cfg_data
);

    localparam int CB = CELL_ID_BITS;
    localparam int PB = PERIMETER_BITS;
    // deviation 16p - P0, signed
    localparam int DW = ((PB + 4 > 16) ? PB + 4 : 16) + 1;
    // deviation change 2cd + 16c^2 with |c| <= 4
    localparam int UW = DW + 4;
    // times lambda (17 bit signed)
    localparam int PW = UW + 17;
    // times 16
    localparam int TW = PW + 4;
    localparam int EW = ppe_pkg::ENERGY_BITS;
    localparam int SW = (TW + 1 > EW + 1) ? TW + 1 : EW + 1;

    // ---------------- configuration ----------------
    logic [15:0] gain_reg;
    logic [15:0] p0_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= ppe_pkg::GAIN_RESET;
            p0_reg   <= ppe_pkg::TARGET_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ppe_pkg::CFG_GAIN)
                gain_reg <= cfg_data;
            else
                p0_reg <= cfg_data;
        end
    end

    // ---------------- pipeline control ----------------
    // global advance: a stage moves when the output register can move
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign adv      = !v5_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ---------------- stage 1: match count, status, deviation ----------------
    logic          src_occ, tgt_occ;
    logic [3:0]    nb_valid;
    logic [CB-1:0] src_id, tgt_id;
    logic [CB-1:0] nb_id [4];
    logic [PB-1:0] src_p, tgt_p;

    assign src_occ  = s_tuser[0];
    assign tgt_occ  = s_tuser[1];
    assign nb_valid = s_tuser[5:2];
    assign src_id   = s_tdata[CB-1:0];
    assign tgt_id   = s_tdata[2*CB-1:CB];
    assign nb_id[0] = s_tdata[3*CB-1:2*CB];
    assign nb_id[1] = s_tdata[4*CB-1:3*CB];
    assign nb_id[2] = s_tdata[5*CB-1:4*CB];
    assign nb_id[3] = s_tdata[6*CB-1:5*CB];
    assign src_p    = s_tdata[6*CB+PB-1:6*CB];
    assign tgt_p    = s_tdata[6*CB+2*PB-1:6*CB+PB];

    logic [2:0]                n_src, n_tgt;
    ppe_pkg::status_t          st1_next;
    logic signed [3:0]         cs1_next, ct1_next;
    logic signed [DW-1:0]      ds1_next, dt1_next;

    always_comb
    begin
        n_src = 3'd0;
        n_tgt = 3'd0;
        for (int k = 0; k < 4; k++)
        begin
            if (nb_valid[k] && nb_id[k] == src_id)
                n_src = n_src + 3'd1;
            if (nb_valid[k] && nb_id[k] == tgt_id)
                n_tgt = n_tgt + 3'd1;
        end

        priority if (!src_occ && !tgt_occ)
            st1_next = ppe_pkg::STATUS_EMPTY;
        else if (src_occ && tgt_occ && src_id == tgt_id)
            st1_next = ppe_pkg::STATUS_SAME;
        else
            st1_next = ppe_pkg::STATUS_OK;

        // source gains the change, target loses it
        cs1_next = ppe_pkg::perim_change(n_src);
        ct1_next = -ppe_pkg::perim_change(n_tgt);

        ds1_next = $signed({{(DW-PB-4){1'b0}}, src_p, 4'b0000})
                 - $signed({{(DW-16){1'b0}}, p0_reg});
        dt1_next = $signed({{(DW-PB-4){1'b0}}, tgt_p, 4'b0000})
                 - $signed({{(DW-16){1'b0}}, p0_reg});
    end

    ppe_pkg::status_t     st1_reg, st2_reg, st3_reg, st4_reg;
    logic                 so1_reg, so2_reg, so3_reg;
    logic                 to1_reg, to2_reg, to3_reg;
    logic signed [3:0]    cs1_reg, ct1_reg;
    logic signed [DW-1:0] ds1_reg, dt1_reg;

    // ---------------- stage 2: (d+16c)^2 - d^2 = 16 * (2cd + 16c^2) ----------------
    logic signed [UW-1:0] us2_next, ut2_next;
    logic signed [UW-1:0] dsx, dtx, csx, ctx;

    always_comb
    begin
        dsx = UW'(ds1_reg);
        dtx = UW'(dt1_reg);
        csx = UW'(cs1_reg);
        ctx = UW'(ct1_reg);
        us2_next = UW'((dsx * csx) * 2 + csx * csx * 16);
        ut2_next = UW'((dtx * ctx) * 2 + ctx * ctx * 16);
    end

    logic signed [UW-1:0] us2_reg, ut2_reg;

    // ---------------- stage 3: multiply by lambda ----------------
    logic signed [PW-1:0] gx;
    logic signed [PW-1:0] ps3_next, pt3_next;

    assign gx       = PW'($signed({1'b0, gain_reg}));
    assign ps3_next = PW'(us2_reg) * gx;
    assign pt3_next = PW'(ut2_reg) * gx;

    logic signed [PW-1:0] ps3_reg, pt3_reg;

    // ---------------- stage 4: sum of present cells ----------------
    logic signed [SW-1:0] ts, tt, sum4_next;

    always_comb
    begin
        ts = so3_reg ? SW'($signed({ps3_reg, 4'b0000})) : '0;
        tt = to3_reg ? SW'($signed({pt3_reg, 4'b0000})) : '0;
        if (st3_reg == ppe_pkg::STATUS_OK)
            sum4_next = ts + tt;
        else
            sum4_next = '0;
    end

    logic signed [SW-1:0] sum4_reg;

    // ---------------- stage 5: saturate into the output register ----------------
    logic [EW-1:0] e5_next;
    logic          fits;

    always_comb
    begin
        // fits when all bits from the sign of a 48-bit value upward agree
        fits = (sum4_reg[SW-1:EW-1] == '0) || (sum4_reg[SW-1:EW-1] == '1);
        if (fits)
            e5_next = sum4_reg[EW-1:0];
        else if (sum4_reg[SW-1])
            e5_next = {1'b1, {(EW-1){1'b0}}};
        else
            e5_next = {1'b0, {(EW-1){1'b1}}};
    end

    logic [EW-1:0] e5_reg;
    logic [1:0]    st5_reg;

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_reg  <= st1_next;
            so1_reg  <= src_occ;
            to1_reg  <= tgt_occ;
            cs1_reg  <= cs1_next;
            ct1_reg  <= ct1_next;
            ds1_reg  <= ds1_next;
            dt1_reg  <= dt1_next;

            st2_reg  <= st1_reg;
            so2_reg  <= so1_reg;
            to2_reg  <= to1_reg;
            us2_reg  <= us2_next;
            ut2_reg  <= ut2_next;

            st3_reg  <= st2_reg;
            so3_reg  <= so2_reg;
            to3_reg  <= to2_reg;
            ps3_reg  <= ps3_next;
            pt3_reg  <= pt3_next;

            st4_reg  <= st3_reg;
            sum4_reg <= sum4_next;

            st5_reg  <= st4_reg;
            e5_reg   <= e5_next;
        end
    end

    assign m_tdata = e5_reg;
    assign m_tuser = st5_reg;

endmodule

// ----- design/potts_perimeter_energy_delta_unit_checker.sv -----
// Port-level checker for potts_perimeter_energy_delta_unit, with its bind.
// Depends on ppe_pkg for status codes.
`timescale 1ns / 1ps

module ppe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // output register empty once reset has been seen at a clock edge
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // input side stalls exactly when a full output register is held
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output stall");

    // error codes carry zero energy
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != 2'(ppe_pkg::STATUS_OK) |-> m_tdata == '0)
        else $error("nonzero energy with error status");

    // no status code outside the defined set
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == 2'(ppe_pkg::STATUS_OK)
                   || m_tuser == 2'(ppe_pkg::STATUS_EMPTY)
                   || m_tuser == 2'(ppe_pkg::STATUS_SAME)))
        else $error("undefined status code");

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind potts_perimeter_energy_delta_unit ppe_checker u_ppe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/potts_perimeter_energy_delta_unit_tb.sv -----
// Self-checking testbench for potts_perimeter_energy_delta_unit: stream driver,
// result monitor and an in-bench energy predictor. Depends on ppe_pkg and the RTL.
`timescale 1ns / 1ps

module potts_perimeter_energy_delta_unit_tb;

    localparam int ID_W    = 16;
    localparam int PERIM_W = 12;
    localparam int TDATA_W = ((6*ID_W + 2*PERIM_W + 7) / 8) * 8;

    localparam longint ENERGY_MAX = (longint'(1) <<< (ppe_pkg::ENERGY_BITS - 1)) - 1;
    localparam longint ENERGY_MIN = -ENERGY_MAX - 1;

    // long receiver hold-off, long enough to back the pipeline up into s_tready
    localparam int LONG_STALL_CYCLES = 300;
    // idle cycles added once the last result is back, before a register write / the end
    localparam int DRAIN_CYCLES = 10;

    // one proposed site copy; nbr[0] is neighbour a
    typedef struct packed {
        logic                     src_occ;
        logic [ID_W-1:0]          src_cell;
        logic                     tgt_occ;
        logic [ID_W-1:0]          tgt_cell;
        logic [3:0]               nvalid;
        logic [3:0][ID_W-1:0]     nbr;
        logic [PERIM_W-1:0]       src_perim;
        logic [PERIM_W-1:0]       tgt_perim;
    } proposal_t;

    typedef struct packed {
        logic [ppe_pkg::ENERGY_BITS-1:0] energy;
        ppe_pkg::status_t                status;
    } energy_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // fields from bit 0: source_cell, target_cell, neighbour_a..d, source_perimeter,
    // target_perimeter_now
    logic [TDATA_W-1:0] s_tdata = '0;
    // fields from bit 0: source_occupied, target_occupied, neighbour_valid[3:0]
    logic [5:0]         s_tuser = '0;

    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // energy_delta (signed)
    logic [ppe_pkg::ENERGY_BITS-1:0] m_tdata;
    // status
    logic [1:0]                      m_tuser;

    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic                         cfg_index = ppe_pkg::CFG_GAIN;
    logic [ppe_pkg::CFG_BITS-1:0] cfg_data = '0;

    potts_perimeter_energy_delta_unit #(
        .CELL_ID_BITS   (ID_W),
        .PERIMETER_BITS (PERIM_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // bench copy of the two registers, updated on each accepted cfg transaction
    logic [ppe_pkg::CFG_BITS-1:0] lambda_cfg = ppe_pkg::GAIN_RESET;
    logic [ppe_pkg::CFG_BITS-1:0] p0_cfg     = ppe_pkg::TARGET_RESET;

    proposal_t      proposal_q[$];      // waiting to be offered
    proposal_t      directed_q[$];      // kept so it can be replayed at other settings
    energy_result_t energy_expect_q[$]; // predicted results, oldest first
    proposal_t      on_bus;             // proposal currently on s_tdata/s_tuser

    int offered_cnt  = 0;  // bumped by the driver
    int accepted_cnt = 0;  // bumped by the monitor
    int mismatch_cnt = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // hold-off requests from the sequence, served by the receiver process
    int stall_requests = 0;
    int stalls_served  = 0;
    int stall_left     = 0;

    // -------------------------------------------------------------------------
    // Predictor
    // -------------------------------------------------------------------------

    // lambda * ((d + 16c)^2 - d^2), d = 16p - P0; units of 2^-16, exact in 64 bits
    function automatic longint cell_energy_term(input logic [PERIM_W-1:0] perim,
                                                input int change);
        longint dev;
        longint dev_new;
        dev     = longint'(perim) * 16 - longint'(p0_cfg);
        dev_new = dev + longint'(change) * 16;
        return (dev_new * dev_new - dev * dev) * longint'(lambda_cfg);
    endfunction

    function automatic energy_result_t predict_energy_delta(input proposal_t p);
        energy_result_t r;
        int     n_src;
        int     n_tgt;
        longint e;
        n_src = 0;
        n_tgt = 0;
        e     = 0;
        r.energy = '0;
        if (!p.src_occ && !p.tgt_occ) begin
            r.status = ppe_pkg::STATUS_EMPTY;
            return r;
        end
        if (p.src_occ && p.tgt_occ && p.src_cell == p.tgt_cell) begin
            r.status = ppe_pkg::STATUS_SAME;
            return r;
        end
        // a neighbour with its valid bit clear belongs to no cell
        for (int k = 0; k < 4; k++) begin
            if (p.nvalid[k]) begin
                if (p.src_occ && p.nbr[k] == p.src_cell)
                    n_src++;
                if (p.tgt_occ && p.nbr[k] == p.tgt_cell)
                    n_tgt++;
            end
        end
        // perimeter change is 4 - 2n; the source gains it, the target loses it
        if (p.src_occ)
            e += cell_energy_term(p.src_perim, 4 - 2*n_src);
        if (p.tgt_occ)
            e += cell_energy_term(p.tgt_perim, -(4 - 2*n_tgt));
        if (e > ENERGY_MAX)
            e = ENERGY_MAX;
        if (e < ENERGY_MIN)
            e = ENERGY_MIN;
        r.energy = e[ppe_pkg::ENERGY_BITS-1:0];
        r.status = ppe_pkg::STATUS_OK;
        return r;
    endfunction

    // -------------------------------------------------------------------------
    // Stimulus generation
    // -------------------------------------------------------------------------

    function automatic proposal_t mk_proposal(
        input logic so, input logic [ID_W-1:0] sc,
        input logic to, input logic [ID_W-1:0] tc,
        input logic [3:0] nv,
        input logic [ID_W-1:0] na, input logic [ID_W-1:0] nb,
        input logic [ID_W-1:0] nc, input logic [ID_W-1:0] nd,
        input logic [PERIM_W-1:0] sp, input logic [PERIM_W-1:0] tp);
        proposal_t p;
        p.src_occ   = so;
        p.src_cell  = sc;
        p.tgt_occ   = to;
        p.tgt_cell  = tc;
        p.nvalid    = nv;
        p.nbr       = {nd, nc, nb, na};
        p.src_perim = sp;
        p.tgt_perim = tp;
        return p;
    endfunction

    // perimeter either anywhere in range or close to the current target P0
    function automatic logic [PERIM_W-1:0] pick_perimeter();
        int v;
        if ($urandom_range(0, 1) == 0)
            return PERIM_W'($urandom);
        v = int'(p0_cfg >> 4) + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
            v = 0;
        if (v > (1 << PERIM_W) - 1)
            v = (1 << PERIM_W) - 1;
        return PERIM_W'(v);
    endfunction

    // mostly plausible lattice neighbourhoods; one in ten is pure noise
    function automatic proposal_t random_proposal();
        proposal_t       p;
        logic [ID_W-1:0] stranger;
        int              pick;
        if ($urandom_range(0, 9) == 0) begin
            p.src_occ   = 1'($urandom);
            p.src_cell  = ID_W'($urandom);
            p.tgt_occ   = 1'($urandom);
            p.tgt_cell  = ID_W'($urandom);
            p.nvalid    = 4'($urandom);
            p.nbr       = {$urandom, $urandom};
            p.src_perim = PERIM_W'($urandom);
            p.tgt_perim = PERIM_W'($urandom);
            return p;
        end
        p.src_occ  = ($urandom_range(0, 9) != 0);
        p.tgt_occ  = ($urandom_range(0, 9) != 0);
        p.src_cell = ID_W'($urandom);
        p.tgt_cell = ($urandom_range(0, 4) == 0) ? p.src_cell : ID_W'($urandom);
        stranger   = ID_W'($urandom);
        for (int k = 0; k < 4; k++) begin
            pick = $urandom_range(0, 3);
            case (pick)
                0:       p.nbr[k] = p.src_cell;
                1:       p.nbr[k] = p.tgt_cell;
                2:       p.nbr[k] = stranger;
                default: p.nbr[k] = ID_W'($urandom);
            endcase
        end
        p.nvalid    = ($urandom_range(0, 2) == 0) ? 4'hF : 4'($urandom);
        p.src_perim = pick_perimeter();
        p.tgt_perim = pick_perimeter();
        return p;
    endfunction

    // -------------------------------------------------------------------------
    // Clock, driver, receiver, monitor
    // -------------------------------------------------------------------------

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Driver: a new proposal only once the previous transaction has gone.
    // s_tvalid is only assigned on falling edges.
    always @(negedge clk)
    begin
        if (rst_n && accepted_cnt == offered_cnt) begin
            if (proposal_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                on_bus = proposal_q.pop_front();
                offered_cnt++;
                s_tvalid <= 1'b1;
                s_tdata  <= {on_bus.tgt_perim, on_bus.src_perim, on_bus.nbr,
                             on_bus.tgt_cell, on_bus.src_cell};
                s_tuser  <= {on_bus.nvalid, on_bus.tgt_occ, on_bus.src_occ};
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus the occasional long hold-off
    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (stall_requests != stalls_served) begin
            stalls_served++;
            stall_left = LONG_STALL_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on each input transaction, check each output transaction
    always @(posedge clk)
    begin
        energy_result_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (energy_expect_q.size() == 0) begin
                    $display("%0t: unexpected result: energy_delta %0d status %0d",
                             $time, $signed(m_tdata), m_tuser);
                    mismatch_cnt++;
                end
                else begin
                    want = energy_expect_q.pop_front();
                    if (m_tdata !== want.energy) begin
                        $display("%0t: energy_delta expected %0d actual %0d", $time,
                                 $signed(want.energy), $signed(m_tdata));
                        mismatch_cnt++;
                    end
                    if (m_tuser !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, m_tuser);
                        mismatch_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                energy_expect_q.push_back(predict_energy_delta(on_bus));
                accepted_cnt++;
            end
        end
    end

    // -------------------------------------------------------------------------
    // Sequence
    // -------------------------------------------------------------------------

    // register writes only happen with the pipeline empty
    task automatic write_register(input logic idx,
                                  input logic [ppe_pkg::CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == ppe_pkg::CFG_GAIN)
            lambda_cfg = value;
        else
            p0_cfg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (proposal_q.size() != 0 || accepted_cnt != offered_cnt
               || energy_expect_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_random(input int n_items, input int send_pct, input int recv_pct,
                              input bit long_stall);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n_items; i++)
            proposal_q.push_back(random_proposal());
        if (long_stall)
            stall_requests++;
        wait_drained();
    endtask

    initial
    begin
        logic [ID_W-1:0] na;
        logic [ID_W-1:0] nb;
        logic [ID_W-1:0] nc;
        logic [ID_W-1:0] nd;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed cases, first at the reset register values
        // neither site in a cell
        directed_q.push_back(mk_proposal(0, 16'h1234, 0, 16'h1234, 4'hF,
            16'h1234, 16'h1234, 16'h1234, 16'h1234, 12'd100, 12'd200));
        directed_q.push_back(mk_proposal(0, 16'hFFFF, 0, 16'h0000, 4'h0,
            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF));
        // both sites in the same cell
        directed_q.push_back(mk_proposal(1, 16'h0042, 1, 16'h0042, 4'h5,
            16'h0042, 16'h0001, 16'h0042, 16'h0002, 12'd16, 12'd20));
        directed_q.push_back(mk_proposal(1, 16'hFFFF, 1, 16'hFFFF, 4'hF,
            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF));
        // one site empty: its id must not count even if it matches the other
        directed_q.push_back(mk_proposal(1, 16'h0007, 0, 16'h0007, 4'hF,
            16'h0007, 16'h0007, 16'h0007, 16'h0007, 12'd16, 12'd16));
        directed_q.push_back(mk_proposal(0, 16'h0007, 1, 16'h0007, 4'hF,
            16'h0007, 16'h0007, 16'h0007, 16'h0007, 12'd16, 12'd16));
        // every neighbour count 0..4 for the source, 4..0 for the target
        for (int n = 0; n <= 4; n++) begin
            na = (n > 0) ? 16'h0001 : 16'h0002;
            nb = (n > 1) ? 16'h0001 : 16'h0002;
            nc = (n > 2) ? 16'h0001 : 16'h0002;
            nd = (n > 3) ? 16'h0001 : 16'h0002;
            directed_q.push_back(mk_proposal(1, 16'h0001, 1, 16'h0002, 4'hF,
                na, nb, nc, nd, 12'd30, 12'd9));
        end
        // matching neighbours with their valid bits clear, or half of them
        directed_q.push_back(mk_proposal(1, 16'h00AA, 1, 16'h0055, 4'h0,
            16'h00AA, 16'h00AA, 16'h0055, 16'h0055, 12'd12, 12'd18));
        directed_q.push_back(mk_proposal(1, 16'h00AA, 1, 16'h0055, 4'hA,
            16'h00AA, 16'h00AA, 16'h00AA, 16'h0055, 12'd12, 12'd18));
        directed_q.push_back(mk_proposal(1, 16'h00AA, 1, 16'h0055, 4'h5,
            16'h00AA, 16'h0055, 16'h00AA, 16'h0055, 12'd12, 12'd18));
        // perimeter and id extremes
        directed_q.push_back(mk_proposal(1, 16'h0000, 1, 16'h0001, 4'hF,
            16'h0000, 16'h0001, 16'h0000, 16'h0001, 12'd0, 12'd0));
        directed_q.push_back(mk_proposal(1, 16'hFFFF, 1, 16'hFFFE, 4'hF,
            16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFE, 12'hFFF, 12'hFFF));
        directed_q.push_back(mk_proposal(1, 16'hFFFF, 0, 16'h0000, 4'hF,
            16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'hFFF, 12'd0));
        directed_q.push_back(mk_proposal(0, 16'h0000, 1, 16'hFFFF, 4'hF,
            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd0, 12'hFFF));
        // perimeter at the target, so the old deviation is zero
        directed_q.push_back(mk_proposal(1, 16'h8000, 1, 16'h7FFF, 4'h9,
            16'h8000, 16'h1111, 16'h2222, 16'h7FFF, 12'd16, 12'd16));

        send_idle_pct = 36;
        recv_idle_pct = 86;
        foreach (directed_q[i])
            proposal_q.push_back(directed_q[i]);
        wait_drained();

        // heaviest weight, P0 at zero; replay the directed set here too
        write_register(ppe_pkg::CFG_GAIN, 16'hFFFF);
        write_register(ppe_pkg::CFG_TARGET, 16'h0000);
        foreach (directed_q[i])
            proposal_q.push_back(directed_q[i]);
        run_random(230, 36, 86, 1'b0);

        // zero weight, largest P0
        write_register(ppe_pkg::CFG_GAIN, 16'h0000);
        write_register(ppe_pkg::CFG_TARGET, 16'hFFFF);
        run_random(200, 86, 36, 1'b0);

        write_register(ppe_pkg::CFG_GAIN, ppe_pkg::CFG_BITS'($urandom));
        write_register(ppe_pkg::CFG_TARGET, ppe_pkg::CFG_BITS'($urandom));
        run_random(250, 86, 36, 1'b0);

        // back-to-back phase with the long output hold-off to fill the pipeline
        write_register(ppe_pkg::CFG_GAIN, 16'hFFFF);
        write_register(ppe_pkg::CFG_TARGET, 16'hFFFF);
        run_random(250, 0, 0, 1'b1);

        write_register(ppe_pkg::CFG_GAIN, 16'h0001);
        write_register(ppe_pkg::CFG_TARGET, ppe_pkg::CFG_BITS'($urandom));
        run_random(250, 0, 0, 1'b0);

        write_register(ppe_pkg::CFG_GAIN, ppe_pkg::GAIN_RESET);
        write_register(ppe_pkg::CFG_TARGET, ppe_pkg::TARGET_RESET);
        run_random(230, 0, 0, 1'b0);

        if (mismatch_cnt == 0)
            $display("potts_perimeter_energy_delta_unit: match");
        else
            $display("potts_perimeter_energy_delta_unit: mismatch");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("potts_perimeter_energy_delta_unit: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ppe_pkg.sv
design/potts_perimeter_energy_delta_unit.sv
design/potts_perimeter_energy_delta_unit_checker.sv
tb/potts_perimeter_energy_delta_unit_tb.sv
